### rtl/core/tmc_pkg.sv
// Shared types and code points for the tape machine core.
package tmc_pkg;

  localparam int WORD_W = 16;

  typedef logic [WORD_W-1:0] word_t;

  // Item operation codes
  typedef enum logic [1:0] {
    OPER_WRITE = 2'd0,
    OPER_READ  = 2'd1,
    OPER_EXEC  = 2'd2,
    OPER_NONE  = 2'd3
  } oper_t;

  // Instruction opcodes (full word, anything above OPC_SETCP is illegal)
  localparam word_t OPC_FWD   = 16'h0000;
  localparam word_t OPC_BACK  = 16'h0001;
  localparam word_t OPC_INC   = 16'h0002;
  localparam word_t OPC_DEC   = 16'h0003;
  localparam word_t OPC_JZ    = 16'h0004;
  localparam word_t OPC_JNZ   = 16'h0005;
  localparam word_t OPC_SHOW  = 16'h0006;
  localparam word_t OPC_IN    = 16'h0007;
  localparam word_t OPC_TEST  = 16'h0008;
  localparam word_t OPC_HALT  = 16'h0009;
  localparam word_t OPC_JMP   = 16'h000A;
  localparam word_t OPC_SETCP = 16'h000B;

endpackage

### rtl/core/tmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/tape_machine_cpu_core.sv
// Tape machine core: 16-bit tape machine with a shared program/data word memory in two copies.
//
// Usage:
//   Item channel (item_valid / item_stall) carries operation, address, data.
//   operation 0 writes a memory word, 1 reads one, 2 executes the instruction
//   at the instruction pointer (data is the value used by the input opcode).
//   Every item yields exactly one result on the result channel
//   (result_valid / result_stall): read_data, display_valid, display_value,
//   halted and error.
// Steps (accept to result register loaded):
//   a write or an execute while halted completes in the issue step; a read
//   or an execute goes issue then decode; taken jumps and set-pointer add
//   operand fetch and address reduction, as the word memory read is registered.
//   The next item is taken in the cycle the current one completes.
// Reset: rst (synchronous) clears pointers and marks, then a clearing pass
//   zeroes every memory word; item_stall stays high meanwhile.
// Stall: while result_stall holds a full result register, the item in work
//   waits at its last step and no new item is taken.
module tape_machine_cpu_core #(
  parameter int MEM_WORDS = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [1:0]        operation,
  input  tmc_pkg::word_t    address,
  input  tmc_pkg::word_t    data,
  output logic              result_valid,
  input  logic              result_stall,
  output tmc_pkg::word_t    read_data,
  output logic              display_valid,
  output tmc_pkg::word_t    display_value,
  output logic              halted,
  output logic              error
);

  import tmc_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);
  localparam logic [AW:0]   WORDS_X   = (AW+1)'(MEM_WORDS);
  localparam logic [16:0]   WORDS17   = 17'(MEM_WORDS);
  // Ceiling reciprocal, exact quotient for any 16-bit dividend
  localparam logic [63:0]   RECIP_FULL =
    ((64'd1 << 32) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
  localparam logic [28:0]   RECIP = RECIP_FULL[28:0];

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_DECODE,
    S_OPERAND,
    S_REDUCE
  } phase_t;

  // Quotient of a word by MEM_WORDS
  function automatic logic [12:0] word_quo(input word_t x);
    logic [44:0] p;
    p = 45'(x) * 45'(RECIP);
    return p[44:32];
  endfunction

  // Remainder given the quotient
  function automatic logic [AW-1:0] word_rem(input word_t x, input logic [12:0] q);
    logic [29:0] m;
    logic [29:0] r;
    m = 30'(q) * 30'(WORDS17);
    r = 30'(x) - m;
    return r[AW-1:0];
  endfunction

  phase_t        phase, phase_next;
  oper_t         item_op;
  word_t         item_addr_raw;
  logic [12:0]   item_q;
  word_t         item_data;
  logic [AW-1:0] ip, ip_next;
  logic [AW-1:0] cp, cp_next;
  logic          zero_mark, zm_next;
  logic          halt_mark, halt_next;
  logic          error_mark, err_next;
  logic          clearing;
  logic [AW-1:0] clr_addr;
  word_t         opnd_raw;
  logic [12:0]   opnd_q;
  logic          set_cp;

  logic          out_free;
  logic          done;
  logic          accept;
  logic          is_exec;
  logic          take_operand;
  logic [AW-1:0] item_addr;
  logic [AW-1:0] ip_plus1;
  logic [AW-1:0] ip_plus2;
  logic [AW:0]   ip_sum2;
  logic [AW-1:0] target;
  word_t         op_word;
  word_t         cell_word;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  word_t         wr_data;
  logic [AW-1:0] rd_a_addr;
  word_t         res_read;
  logic          res_dv;
  word_t         res_dval;

  // Two copies of the word memory: port a fetches opcode/operand/item word,
  // port b fetches the current cell. Both take every write.
  tmc_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_a_addr),
    .rd_data (op_word)
  );

  tmc_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (cp),
    .rd_data (cell_word)
  );

  // Address arithmetic
  assign item_addr = word_rem(item_addr_raw, item_q);
  assign target    = word_rem(opnd_raw, opnd_q);
  assign ip_plus1  = (ip == LAST_ADDR) ? '0 : ip + AW'(1);
  assign ip_sum2   = {1'b0, ip} + (AW+1)'(2);
  assign ip_plus2  = (ip_sum2 >= WORDS_X) ? AW'(ip_sum2 - WORDS_X) : ip_sum2[AW-1:0];

  assign is_exec   = (item_op == OPER_EXEC);
  assign out_free  = !result_valid || !result_stall;
  assign item_stall = rst || clearing || !((phase == S_IDLE) || done);
  assign accept    = item_valid && !item_stall;

  assign take_operand = is_exec &&
    (((op_word == OPC_JZ) && zero_mark) || ((op_word == OPC_JNZ) && !zero_mark) ||
     (op_word == OPC_JMP) || (op_word == OPC_SETCP));

  // Step sequencing and memory port control
  always_comb begin
    phase_next = phase;
    ip_next    = ip;
    cp_next    = cp;
    zm_next    = zero_mark;
    halt_next  = halt_mark;
    err_next   = error_mark;
    done       = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = cp;
    wr_data    = cell_word;
    rd_a_addr  = ip;
    res_read   = '0;
    res_dv     = 1'b0;
    res_dval   = '0;

    case (phase)
      S_IDLE: begin
      end
      S_ISSUE: begin
        rd_a_addr = is_exec ? ip : item_addr;
        if (item_op == OPER_READ || (is_exec && !halt_mark)) begin
          phase_next = S_DECODE;
        end else if (out_free) begin
          done = 1'b1;
          if (item_op == OPER_WRITE) begin
            wr_en   = 1'b1;
            wr_addr = item_addr;
            wr_data = item_data;
          end
        end
      end
      S_DECODE: begin
        // Same address while held, so the read data stays put
        rd_a_addr = take_operand ? ip_plus1 : (is_exec ? ip : item_addr);
        if (take_operand) begin
          phase_next = S_OPERAND;
        end else if (out_free) begin
          done = 1'b1;
          if (!is_exec) begin
            res_read = op_word;
          end else begin
            ip_next = ip_plus1;
            case (op_word)
              OPC_FWD:   cp_next = (cp == LAST_ADDR) ? '0 : cp + AW'(1);
              OPC_BACK:  cp_next = (cp == '0) ? LAST_ADDR : cp - AW'(1);
              OPC_INC: begin
                wr_en   = 1'b1;
                wr_data = cell_word + 16'd1;
              end
              OPC_DEC: begin
                wr_en   = 1'b1;
                wr_data = cell_word - 16'd1;
              end
              OPC_JZ, OPC_JNZ: ip_next = ip_plus2;   // not taken: skip operand
              OPC_SHOW: begin
                res_dv   = 1'b1;
                res_dval = cell_word;
              end
              OPC_IN: begin
                wr_en   = 1'b1;
                wr_data = item_data;
              end
              OPC_TEST:  zm_next = (cell_word == '0);
              OPC_HALT: begin
                halt_next = 1'b1;
                ip_next   = ip;
              end
              OPC_JMP, OPC_SETCP: ip_next = ip;      // handled via operand path
              default: begin
                halt_next = 1'b1;
                err_next  = 1'b1;
                ip_next   = ip;
              end
            endcase
          end
        end
      end
      S_OPERAND: begin
        phase_next = S_REDUCE;
      end
      S_REDUCE: begin
        if (out_free) begin
          done = 1'b1;
          if (set_cp) begin
            cp_next = target;
            ip_next = ip_plus2;
          end else begin
            ip_next = target;
          end
        end
      end
      default: begin
        phase_next = S_IDLE;
      end
    endcase

    if (done) begin
      phase_next = S_IDLE;
    end
    if (accept) begin
      phase_next = S_ISSUE;
    end

    // Post-reset clearing pass owns the write port
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end
  end

  // State, item capture and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= S_IDLE;
      ip           <= '0;
      cp           <= '0;
      zero_mark    <= 1'b0;
      halt_mark    <= 1'b0;
      error_mark   <= 1'b0;
      clearing     <= 1'b1;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      phase      <= phase_next;
      ip         <= ip_next;
      cp         <= cp_next;
      zero_mark  <= zm_next;
      halt_mark  <= halt_next;
      error_mark <= err_next;

      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == LAST_ADDR) begin
          clearing <= 1'b0;
        end
      end

      if (done) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end

    if (accept) begin
      item_op       <= oper_t'(operation);
      item_addr_raw <= address;
      item_q        <= word_quo(address);
      item_data     <= data;
    end

    if (phase == S_DECODE) begin
      set_cp <= (op_word == OPC_SETCP);
    end

    if (phase == S_OPERAND) begin
      opnd_raw <= op_word;
      opnd_q   <= word_quo(op_word);
    end

    if (done) begin
      read_data     <= res_read;
      display_valid <= res_dv;
      display_value <= res_dval;
      halted        <= halt_next;
      error         <= err_next;
    end
  end

`ifndef SYNTHESIS
  a_error_implies_halt: assert property (@(posedge clk) disable iff (rst)
    error_mark |-> halt_mark)
    else $error("error mark set without halt mark");

  a_halt_freezes_ip: assert property (@(posedge clk) disable iff (rst)
    halt_mark |=> (halt_mark && $stable(ip)))
    else $error("halted machine changed its instruction pointer");

  a_no_late_write: assert property (@(posedge clk) disable iff (rst)
    (phase == S_OPERAND || phase == S_REDUCE) |-> !wr_en)
    else $error("memory write during operand fetch or reduction");

  a_done_needs_slot: assert property (@(posedge clk) disable iff (rst)
    done |-> out_free)
    else $error("step completed into an occupied result register");
`endif

endmodule
